### rtl/core/prloc_pkg.sv
// ----------------------------------------------------------------------------
// prloc_pkg
// types, constants and register map of the point reflection block
// ----------------------------------------------------------------------------
package prloc_pkg;

   localparam int FRAC_BITS = 16;
   // quotient bits produced by the divider chain (quotient of twice the numerator, before rounding)
   localparam int QB        = 36;
   localparam int NUM_W     = 100;
   localparam int DEN_W     = 67;
   localparam int REM_W     = DEN_W + QB;
   localparam int ADDR_W    = 5;

   localparam logic [63:0] ONE2 = 64'd1 << (2 * FRAC_BITS);

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_CENTRE = 2'd1;
   localparam logic [1:0] STATUS_SAT    = 2'd2;

   localparam logic [ADDR_W-1:0] REG_AXIS_MODE = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] REG_SLOPE     = ADDR_W'(4);
   localparam logic [ADDR_W-1:0] REG_OFFSET    = ADDR_W'(8);
   localparam logic [ADDR_W-1:0] REG_CENTRE_X  = ADDR_W'(12);
   localparam logic [ADDR_W-1:0] REG_CENTRE_Y  = ADDR_W'(16);
   localparam logic [ADDR_W-1:0] REG_RADIUS    = ADDR_W'(20);

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } prloc_req_type;

   typedef struct packed {
      logic signed [31:0] image_x;
      logic signed [31:0] image_y;
      logic [1:0]         status;
   } prloc_rsp_type;

   typedef struct packed {
      logic               axis_mode;
      logic signed [31:0] line_slope;
      logic signed [31:0] line_offset;
      logic signed [31:0] circle_center_x;
      logic signed [31:0] circle_center_y;
      logic [30:0]        circle_radius;
   } prloc_cfg_type;

   typedef struct packed {
      logic [REM_W-1:0]   rem_x;
      logic [REM_W-1:0]   rem_y;
      logic [REM_W-1:0]   dsh;
      logic [QB-1:0]      q_x;
      logic [QB-1:0]      q_y;
      logic               neg_x;
      logic               neg_y;
      logic               ovf_x;
      logic               ovf_y;
      logic               zero;
      logic signed [31:0] off_x;
      logic signed [31:0] off_y;
   } prloc_div_type;

endpackage

### rtl/core/prloc_front.sv
// ----------------------------------------------------------------------------
// prloc_front
// products, numerators and denominator, then divider chain set-up
// ----------------------------------------------------------------------------
module prloc_front import prloc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  prloc_cfg_type cfg,
   input  logic          in_valid,
   input  prloc_req_type in_data,
   output logic          out_valid,
   output prloc_div_type out_data
);

   logic [4:0] valid_ff, valid_in;

   // stage 1
   logic signed [32:0] x33, y33, dx, dy, ymb, m33;
   logic signed [65:0] pa_ff, pb_ff, pc_ff, pa_in, pb_in, pc_in;
   logic signed [32:0] u_ff, v_ff, u_in, v_in;
   // stage 2
   logic [63:0]        k64;
   logic signed [31:0] khi;
   logic signed [65:0] lu_ff, hu_ff, lv_ff, hv_ff, lu_in, hu_in, lv_in, hv_in;
   logic signed [NUM_W-1:0] t1x_ff, t1y_ff, t1x_in, t1y_in, pa_w, pb_w, b_w;
   logic [DEN_W-1:0]   d2_ff, d2_in;
   // stage 3
   logic signed [NUM_W-1:0] nx_ff, ny_ff, nx_in, ny_in, ku, kv;
   logic [DEN_W-1:0]   d3_ff;
   logic               z3_ff, z3_in;
   // stage 4
   logic [NUM_W-1:0]   mx_ff, my_ff, mx_in, my_in;
   logic               sx_ff, sy_ff;
   logic [DEN_W-1:0]   d4_ff;
   logic               z4_ff;
   // stage 5
   prloc_div_type      div_ff, div_in;
   logic [REM_W-1:0]   rx, ry, dlim;

   assign valid_in = {valid_ff[3:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: three shared multipliers
   always_comb begin
      x33   = 33'(in_data.point_x);
      y33   = 33'(in_data.point_y);
      m33   = 33'(cfg.line_slope);
      dx    = x33 - 33'(cfg.circle_center_x);
      dy    = y33 - 33'(cfg.circle_center_y);
      ymb   = y33 - 33'(cfg.line_offset);
      pa_in = cfg.axis_mode ? dx * dx : x33 * m33;
      pb_in = cfg.axis_mode ? dy * dy : ymb * m33;
      pc_in = cfg.axis_mode ? $signed({2'b00, cfg.circle_radius}) *
                              $signed({2'b00, cfg.circle_radius}) : m33 * m33;
      u_in  = cfg.axis_mode ? dx : x33;
      v_in  = cfg.axis_mode ? dy : y33;
   end

   // stage 2: k (or r squared) split into halves for the 64 by 33 products
   always_comb begin
      k64    = cfg.axis_mode ? 64'(pc_ff) : ONE2 - 64'(pc_ff);
      khi    = $signed(k64[63:32]);
      lu_in  = $signed({1'b0, k64[31:0]}) * u_ff;
      lv_in  = $signed({1'b0, k64[31:0]}) * v_ff;
      hu_in  = 66'(khi * u_ff);
      hv_in  = 66'(khi * v_ff);
      pa_w   = NUM_W'(pa_ff);
      pb_w   = NUM_W'(pb_ff);
      b_w    = NUM_W'(cfg.line_offset);
      t1x_in = cfg.axis_mode ? '0 : pb_w <<< (FRAC_BITS + 1);
      t1y_in = cfg.axis_mode ? '0 :
               (pa_w <<< (FRAC_BITS + 1)) + (b_w <<< (2 * FRAC_BITS + 1));
      d2_in  = cfg.axis_mode ? DEN_W'(pa_ff) + DEN_W'(pb_ff)
                             : DEN_W'(ONE2) + DEN_W'(pc_ff);
   end

   // stage 3: numerators
   always_comb begin
      ku    = (NUM_W'(hu_ff) <<< 32) + NUM_W'(lu_ff);
      kv    = (NUM_W'(hv_ff) <<< 32) + NUM_W'(lv_ff);
      nx_in = ku + t1x_ff;
      ny_in = cfg.axis_mode ? kv : t1y_ff - kv;
      z3_in = cfg.axis_mode && (d2_ff == '0);
   end

   // stage 4: sign and magnitude
   assign mx_in = nx_ff[NUM_W-1] ? NUM_W'(-nx_ff) : NUM_W'(nx_ff);
   assign my_in = ny_ff[NUM_W-1] ? NUM_W'(-ny_ff) : NUM_W'(ny_ff);

   // stage 5: doubled magnitude, overflow test, divisor aligned to top bit
   always_comb begin
      rx           = REM_W'({mx_ff, 1'b0});
      ry           = REM_W'({my_ff, 1'b0});
      dlim         = REM_W'(d4_ff) << QB;
      div_in.rem_x = rx;
      div_in.rem_y = ry;
      div_in.dsh   = REM_W'(d4_ff) << (QB - 1);
      div_in.q_x   = '0;
      div_in.q_y   = '0;
      div_in.neg_x = sx_ff;
      div_in.neg_y = sy_ff;
      div_in.ovf_x = rx >= dlim;
      div_in.ovf_y = ry >= dlim;
      div_in.zero  = z4_ff;
      div_in.off_x = cfg.axis_mode ? cfg.circle_center_x : '0;
      div_in.off_y = cfg.axis_mode ? cfg.circle_center_y : '0;
   end

   always_ff @(posedge clock) begin
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      pc_ff  <= pc_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      lu_ff  <= lu_in;
      hu_ff  <= hu_in;
      lv_ff  <= lv_in;
      hv_ff  <= hv_in;
      t1x_ff <= t1x_in;
      t1y_ff <= t1y_in;
      d2_ff  <= d2_in;
      nx_ff  <= nx_in;
      ny_ff  <= ny_in;
      d3_ff  <= d2_ff;
      z3_ff  <= z3_in;
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      sx_ff  <= nx_ff[NUM_W-1];
      sy_ff  <= ny_ff[NUM_W-1];
      d4_ff  <= d3_ff;
      z4_ff  <= z3_ff;
      div_ff <= div_in;
   end

   assign out_valid = valid_ff[4];
   assign out_data  = div_ff;

endmodule

### rtl/core/prloc_div_cell.sv
// ----------------------------------------------------------------------------
// prloc_div_cell
// one restoring divide step for both coordinates
// ----------------------------------------------------------------------------
module prloc_div_cell import prloc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  prloc_div_type in_data,
   output logic          out_valid,
   output prloc_div_type out_data
);

   logic          valid_ff;
   prloc_div_type data_ff, data_in;
   logic          gx, gy;

   always_comb begin
      data_in       = in_data;
      gx            = in_data.rem_x >= in_data.dsh;
      gy            = in_data.rem_y >= in_data.dsh;
      data_in.rem_x = gx ? in_data.rem_x - in_data.dsh : in_data.rem_x;
      data_in.rem_y = gy ? in_data.rem_y - in_data.dsh : in_data.rem_y;
      data_in.q_x   = {in_data.q_x[QB-2:0], gx};
      data_in.q_y   = {in_data.q_y[QB-2:0], gy};
      data_in.dsh   = in_data.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/core/prloc_back.sv
// ----------------------------------------------------------------------------
// prloc_back
// rounding, sign, centre offset and saturation into the result register
// ----------------------------------------------------------------------------
module prloc_back import prloc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  prloc_div_type in_data,
   output logic          out_valid,
   output prloc_rsp_type out_data
);

   logic          valid_ff;
   prloc_rsp_type rsp_ff, rsp_in;
   logic [31:0]   ix, iy;
   logic          sx, sy;

   function automatic logic [32:0] finish(input logic [QB-1:0] q, input logic neg,
                                          input logic ovf, input logic signed [31:0] off);
      logic [QB:0]          qr;
      logic signed [QB+1:0] sv;
      logic signed [QB+2:0] sum;
      logic [32:0]          res;
      qr  = ({1'b0, q} + (QB+1)'(1)) >> 1;
      sv  = neg ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
      sum = (QB+3)'(sv) + (QB+3)'(off);
      if (ovf) begin
         res = neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
      end else if (sum < -(QB+3)'(64'sh8000_0000)) begin
         res = {1'b1, 32'h8000_0000};
      end else if (sum > (QB+3)'(64'sh7FFF_FFFF)) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else begin
         res = {1'b0, sum[31:0]};
      end
      return res;
   endfunction

   always_comb begin
      {sx, ix} = finish(in_data.q_x, in_data.neg_x, in_data.ovf_x, in_data.off_x);
      {sy, iy} = finish(in_data.q_y, in_data.neg_y, in_data.ovf_y, in_data.off_y);
      if (in_data.zero) begin
         rsp_in.image_x = '0;
         rsp_in.image_y = '0;
         rsp_in.status  = STATUS_CENTRE;
      end else begin
         rsp_in.image_x = $signed(ix);
         rsp_in.image_y = $signed(iy);
         rsp_in.status  = (sx || sy) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

### rtl/core/point_reflection_line_or_circle.sv
// ----------------------------------------------------------------------------
// point_reflection_line_or_circle
// mirrors a point across a line or inverts it in a circle, fully pipelined
// ----------------------------------------------------------------------------
// pipeline: 5 set-up stages, 36 divider cells and 1 output stage lie between
//   start and rsp_valid; the divider chain sets the depth
// throughput: one point per cycle, busy is never raised
// results are strobed for one cycle on rsp_valid, the receiver cannot stall
// reset: synchronous, clears the pipeline valids and sets the registers to
//   line mode, slope 0, offset 0, centre (0,0), radius 1.0
module point_reflection_line_or_circle import prloc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // point transfer
   input  logic              start,
   output logic              busy,
   input  prloc_req_type     req_data,
   // result transfer
   output logic              rsp_valid,
   output prloc_rsp_type     rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   prloc_cfg_type cfg_ff, cfg_in;
   logic          wr_en;

   // divider chain taps: index 0 is the front-end output
   logic          chain_valid [QB+1];
   prloc_div_type chain_data  [QB+1];

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // register writes, unknown addresses are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr)
            REG_AXIS_MODE: cfg_in.axis_mode       = pwdata[0];
            REG_SLOPE:     cfg_in.line_slope      = $signed(pwdata);
            REG_OFFSET:    cfg_in.line_offset     = $signed(pwdata);
            REG_CENTRE_X:  cfg_in.circle_center_x = $signed(pwdata);
            REG_CENTRE_Y:  cfg_in.circle_center_y = $signed(pwdata);
            REG_RADIUS:    cfg_in.circle_radius   = pwdata[30:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_mode       <= 1'b0;
         cfg_ff.line_slope      <= '0;
         cfg_ff.line_offset     <= '0;
         cfg_ff.circle_center_x <= '0;
         cfg_ff.circle_center_y <= '0;
         cfg_ff.circle_radius   <= 31'(64'd1 << FRAC_BITS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (paddr)
         REG_AXIS_MODE: prdata = {31'd0, cfg_ff.axis_mode};
         REG_SLOPE:     prdata = cfg_ff.line_slope;
         REG_OFFSET:    prdata = cfg_ff.line_offset;
         REG_CENTRE_X:  prdata = cfg_ff.circle_center_x;
         REG_CENTRE_Y:  prdata = cfg_ff.circle_center_y;
         REG_RADIUS:    prdata = {1'b0, cfg_ff.circle_radius};
         default:       prdata = '0;
      endcase
   end

   // products and numerators
   prloc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // one quotient bit per cell, most significant first
   for (genvar i = 0; i < QB; i++) begin : g_cell
      prloc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // rounding and saturation
   prloc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[QB]),
      .in_data   (chain_data[QB]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

### rtl/core/prloc_checker.sv
// ----------------------------------------------------------------------------
// prloc_checker
// port-level checks of the point reflection block
// ----------------------------------------------------------------------------
module prloc_checker import prloc_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          start,
   input logic          busy,
   input logic          rsp_valid,
   input prloc_rsp_type rsp_data
);

   // no result can leave in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe straight after reset");

   // every result leaves exactly the pipeline depth after its point was taken
   // (5 set-up stages, one stage per divider cell, 1 output stage)
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, QB + 6))
      else $error("result without a point taken at the pipeline depth before");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_CENTRE ||
                     rsp_data.status == STATUS_SAT))
      else $error("undefined status code");

   a_centre_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_CENTRE) |->
         (rsp_data.image_x == 0 && rsp_data.image_y == 0))
      else $error("centre point image not zero");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_SAT) |->
         (rsp_data.image_x == 32'sh7FFF_FFFF || rsp_data.image_x == 32'sh8000_0000 ||
          rsp_data.image_y == 32'sh7FFF_FFFF || rsp_data.image_y == 32'sh8000_0000))
      else $error("saturated status without a clamped coordinate");

endmodule

bind point_reflection_line_or_circle prloc_checker u_prloc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### dv/point_reflection_line_or_circle_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_reflection_line_or_circle_test
// self-checking bench for the point mirror: line reflection and circle
// inversion, compared point by point against an exact 200-bit predictor
// ----------------------------------------------------------------------------
module point_reflection_line_or_circle_test;
   import prloc_pkg::*;

   localparam int LATENCY = 42;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   prloc_req_type     req_data;
   logic              rsp_valid;
   prloc_rsp_type     rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   point_reflection_line_or_circle u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor copy of the registers
   prloc_cfg_type mirror_cfg;

   prloc_req_type point_queue[$];
   prloc_rsp_type image_queue[$];
   int            error_count;
   int            points_sent;
   int            images_seen;
   int            centre_hits;
   int            sat_hits;
   int            circle_points;
   bit            hold_sender;

   // ------------------------------------------------------------------------
   // predictor: exact signed arithmetic in 200-bit containers
   // ------------------------------------------------------------------------
   typedef logic signed [199:0] big_t;

   // rounded to nearest, ties away from zero; den always positive
   function automatic big_t div_round(big_t num, big_t den);
      big_t mag;
      big_t quo;
      big_t rem;
      mag = (num < 0) ? -num : num;
      quo = mag / den;
      rem = mag % den;
      if ((rem <<< 1) >= den) quo = quo + 1;
      return (num < 0) ? -quo : quo;
   endfunction

   function automatic logic [31:0] clamp32(big_t v, inout bit flag);
      if (v > big_t'(32'sh7FFF_FFFF)) begin
         flag = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -big_t'(64'sh8000_0000)) begin
         flag = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic prloc_rsp_type mirror_point(prloc_req_type p);
      prloc_rsp_type res;
      big_t px, py, m, b, m2, k, den, nx, ny, ix, iy, x0, y0, dx, dy, s, r2;
      bit   sat;
      px  = big_t'(p.point_x);
      py  = big_t'(p.point_y);
      sat = 1'b0;
      res = '0;
      if (!mirror_cfg.axis_mode) begin
         m   = big_t'(mirror_cfg.line_slope);
         b   = big_t'(mirror_cfg.line_offset);
         m2  = m * m;
         k   = (big_t'(1) <<< (2 * FRAC_BITS)) - m2;
         den = (big_t'(1) <<< (2 * FRAC_BITS)) + m2;
         nx  = k * px + ((m * (py - b)) <<< (FRAC_BITS + 1));
         ny  = ((m * px) <<< (FRAC_BITS + 1)) - k * py + (b <<< (2 * FRAC_BITS + 1));
         ix  = div_round(nx, den);
         iy  = div_round(ny, den);
      end else begin
         x0 = big_t'(mirror_cfg.circle_center_x);
         y0 = big_t'(mirror_cfg.circle_center_y);
         dx = px - x0;
         dy = py - y0;
         s  = dx * dx + dy * dy;
         if (s == 0) begin
            res.status = STATUS_CENTRE;
            return res;
         end
         r2 = big_t'({1'b0, mirror_cfg.circle_radius}) * big_t'({1'b0, mirror_cfg.circle_radius});
         ix = x0 + div_round(r2 * dx, s);
         iy = y0 + div_round(r2 * dy, s);
      end
      res.image_x = clamp32(ix, sat);
      res.image_y = clamp32(iy, sat);
      res.status  = sat ? STATUS_SAT : STATUS_OK;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   // ------------------------------------------------------------------------
   // clock and run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // driver: bursts of transfers with random gaps, changes on the falling edge
   // ------------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         // a transfer happened at the last rising edge if start was high and busy low
         automatic bit can_send;
         can_send = !hold_sender && point_queue.size() > 0;
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (can_send) begin
            req_data <= point_queue[0];
            start <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               // some bursts run back to back, others leave a gap after
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // acceptance at the rising edge: predict and pop
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         image_queue.push_back(mirror_point(point_queue[0]));
         if (mirror_cfg.axis_mode) circle_points++;
         void'(point_queue.pop_front());
         points_sent++;
      end
   end

   // ------------------------------------------------------------------------
   // monitor: each strobed result is compared with the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         prloc_rsp_type want;
         images_seen++;
         if (image_queue.size() == 0) begin
            report_mismatch("unexpected result image_x", rsp_data.image_x, '0);
         end else begin
            want = image_queue.pop_front();
            if (want.status == STATUS_CENTRE) centre_hits++;
            if (want.status == STATUS_SAT) sat_hits++;
            if (rsp_data.image_x !== want.image_x)
               report_mismatch("image_x", rsp_data.image_x, want.image_x);
            if (rsp_data.image_y !== want.image_y)
               report_mismatch("image_y", rsp_data.image_y, want.image_y);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
         end
      end
   end

   // ------------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------------
   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (addr)
         REG_AXIS_MODE: mirror_cfg.axis_mode       = value[0];
         REG_SLOPE:     mirror_cfg.line_slope      = value;
         REG_OFFSET:    mirror_cfg.line_offset     = value;
         REG_CENTRE_X:  mirror_cfg.circle_center_x = value;
         REG_CENTRE_Y:  mirror_cfg.circle_center_y = value;
         REG_RADIUS:    mirror_cfg.circle_radius   = value[30:0];
         default: ;
      endcase
   endtask

   // waits for the pipeline to drain before the registers may change
   task automatic drain(int limit_cycles);
      int n;
      n = 0;
      while ((point_queue.size() > 0 || image_queue.size() > 0 || start) &&
             n < limit_cycles) begin
         @(posedge clock);
         n++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000 + $urandom_range(0, 3);
         1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2, 3:    return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      endcase
   endfunction

   task automatic push_point(logic [31:0] px, logic [31:0] py);
      prloc_req_type p;
      p.point_x = px;
      p.point_y = py;
      point_queue.push_back(p);
   endtask

   task automatic random_points(int count);
      logic [31:0] px;
      logic [31:0] py;
      repeat (count) begin
         px = pick_coord();
         py = pick_coord();
         // aim at the circle centre now and then, and nearby
         if (mirror_cfg.axis_mode && $urandom_range(0, 9) == 0) begin
            px = mirror_cfg.circle_center_x + $urandom_range(0, 2);
            py = mirror_cfg.circle_center_y;
         end
         push_point(px, py);
      end
   endtask

   task automatic set_line(logic [31:0] slope, logic [31:0] offset);
      csr_write(REG_AXIS_MODE, 32'd0);
      csr_write(REG_SLOPE, slope);
      csr_write(REG_OFFSET, offset);
   endtask

   task automatic set_circle(logic [31:0] cx, logic [31:0] cy, logic [31:0] rad);
      csr_write(REG_AXIS_MODE, 32'd1);
      csr_write(REG_CENTRE_X, cx);
      csr_write(REG_CENTRE_Y, cy);
      csr_write(REG_RADIUS, rad);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      hold_sender = 1'b0;
      error_count = 0;
      points_sent = 0;
      images_seen = 0;
      centre_hits = 0;
      sat_hits = 0;
      circle_points = 0;
      mirror_cfg = '0;
      mirror_cfg.circle_radius = 31'(1 << FRAC_BITS);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, line y = 0
      push_point(32'h0001_0000, 32'h0002_0000);
      push_point(32'h8000_0000, 32'h7FFF_FFFF);
      push_point(32'h7FFF_FFFF, 32'h8000_0000);
      push_point(32'h0000_0000, 32'h0000_0000);
      drain(2000);

      // steep line with offset, saturating points
      set_line(32'h7FFF_FFFF, 32'h8000_0000);
      push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_point(32'h8000_0000, 32'h0000_0001);
      push_point(32'hFFFF_FFFF, 32'h0000_0000);
      drain(2000);
      set_line(32'h8000_0000, 32'h7FFF_FFFF);
      push_point(32'h0001_0000, 32'h8000_0000);
      push_point(32'h0000_8000, 32'h0000_8000);
      drain(2000);

      // unit circle at origin: centre point, boundary, far and near points
      set_circle(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
      push_point(32'h0000_0000, 32'h0000_0000);
      push_point(32'h0001_0000, 32'h0000_0000);
      push_point(32'h0000_0001, 32'h0000_0000);
      push_point(32'h7FFF_FFFF, 32'h8000_0000);
      drain(2000);

      // largest radius, extreme centre, zero radius
      set_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_point(32'h8000_0000, 32'h7FFF_FFFF);
      push_point(32'h7FFF_FFFF, 32'h8000_0000);
      push_point(32'h8000_0001, 32'h7FFF_FFFF);
      drain(2000);
      csr_write(REG_RADIUS, 32'd0);
      push_point(32'h1234_5678, 32'h8765_4321);
      drain(2000);

      // random phases over several settings, sender held idle in between
      for (int phase = 0; phase < 26; phase++) begin
         if ($urandom_range(0, 1) == 0)
            set_line(($urandom_range(0, 3) == 0) ? $urandom() :
                     32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
                     pick_coord());
         else
            set_circle(pick_coord(), pick_coord(),
                       ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0010_0000));
         random_points(50);
         // pause once mid-phase until every expected result has come
         if (phase == 5) begin
            wait (point_queue.size() < 25);
            hold_sender = 1'b1;
            while (image_queue.size() > 0 || start) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain(20000);
      end

      drain(20000);
      $display("covered %0d points (%0d in circle mode), %0d results checked",
               points_sent, circle_points, images_seen);
      $display("centre hits %0d, saturated results %0d", centre_hits, sat_hits);
      if (error_count == 0 && image_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (image_queue.size() != 0) $display("%0d results never arrived", image_queue.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
